>>> rtl/ptdt_pkg.sv
// Shared constants and state type for the trial-division primality tester.
`timescale 1ns / 1ps

package ptdt_pkg;

  // Candidate width in bits (signed two's complement)
  localparam int VALUE_WIDTH = 32;

  // Stream data width: candidate rounded up to whole bytes
  localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

  // Bit counter width for one serial division pass
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FIN
  } ptdt_state_t;

endpackage

>>> rtl/prime_trial_division_test.sv
// Top level: bit-serial trial-division primality tester, one candidate per item.
// Negative values, 0, 1, 2, 3 and even values are decided from the input alone and go
//   straight to the finish state; other values try D odd divisors (up to about 23170
//   at 32 bits), each with VALUE_WIDTH restoring-divider steps and then a check.
// One item at a time: the next candidate is taken only once the last result is in the
//   output register. Reset (rst_n, synchronous, active low) clears control only.
`timescale 1ns / 1ps

module prime_trial_division_test (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ptdt_pkg::TDATA_W-1:0] in_tdata,   // [VALUE_WIDTH-1:0] candidate
  input  logic                        in_tlast,   // last_in_range
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ptdt_pkg::TDATA_W-1:0] out_tdata,  // [VALUE_WIDTH-1:0] tested_value
  output logic                        out_tuser,  // is_prime
  output logic                        out_tlast   // last
);

  import ptdt_pkg::*;

  localparam int VW = VALUE_WIDTH;

  ptdt_state_t state_r, state_nxt;

  logic [VW-1:0]    n_r, n_nxt;
  logic [VW-1:0]    div_r, div_nxt;
  logic [VW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             prime_r, prime_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    tested_r, tested_nxt;
  logic             out_prime_r, out_prime_nxt;
  logic             out_last_r, out_last_nxt;

  logic [VW-1:0] cand;
  logic          cand_neg, cand_lt2, cand_lt4, cand_even;
  logic          quick_done, quick_prime;
  logic [VW-1:0] trial;
  logic          trial_ge;
  logic          cnt_last;
  logic          out_free;
  logic          bound_hit;

  // Decode the incoming candidate for the trivial cases
  assign cand        = in_tdata[VW-1:0];
  assign cand_neg    = cand[VW-1];
  assign cand_lt2    = cand < VW'(2);
  assign cand_lt4    = cand < VW'(4);
  assign cand_even   = ~cand[0];
  assign quick_done  = cand_neg | cand_lt2 | cand_lt4 | cand_even;
  assign quick_prime = ~cand_neg & ~cand_lt2 & cand_lt4;

  // One restoring division step: shift in the next dividend bit
  assign trial    = {rem_r[VW-2:0], quo_r[VW-1]};
  assign trial_ge = trial >= div_r;
  assign cnt_last = cnt_r == CNT_W'(VW - 1);

  // Divisor past the square-root bound once it exceeds the quotient
  assign bound_hit = div_r > quo_r;

  assign out_free  = ~out_valid_r | out_tready;
  assign in_tready = state_r == ST_IDLE;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = quick_done ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (bound_hit || rem_r == '0) ? ST_FIN : ST_DIV;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register updates
  always_comb begin
    n_nxt         = n_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    prime_nxt     = prime_r;
    tested_nxt    = tested_r;
    out_prime_nxt = out_prime_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      ST_IDLE: begin
        // Capture the item and start with divisor three
        if (in_tvalid) begin
          n_nxt     = cand;
          last_nxt  = in_tlast;
          prime_nxt = quick_prime;
          div_nxt   = VW'(3);
          quo_nxt   = cand;
          rem_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        // Advance the serial divider by one bit
        rem_nxt = trial_ge ? trial - div_r : trial;
        quo_nxt = {quo_r[VW-2:0], trial_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_CHECK: begin
        // Stop at the bound or on a factor, else try the next odd divisor
        if (bound_hit) begin
          prime_nxt = 1'b1;
        end else if (rem_r == '0) begin
          prime_nxt = 1'b0;
        end else begin
          div_nxt = div_r + VW'(2);
          quo_nxt = n_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          tested_nxt    = n_r;
          out_prime_nxt = prime_r;
          out_last_nxt  = last_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r & ~out_tready;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    last_r      <= last_nxt;
    prime_r     <= prime_nxt;
    tested_r    <= tested_nxt;
    out_prime_r <= out_prime_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(tested_r);
  assign out_tuser  = out_prime_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  // Remainder always stays below the divisor while dividing
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // Only odd divisors from three upward are tried
  a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_r[0] && div_r >= VW'(3)))
    else $error("divisor not odd or below three");

  // An accepted item always leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("block idle right after accepting an item");

  // A prime result is never reported for a negative value
  a_prime_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> !tested_r[VW-1])
    else $error("negative value flagged prime");
`endif

endmodule
